[rtl/core/scan_min_range_steering_defines.svh]
// ----------------------------------------------------------------------------
// scan_min_range_steering_defines.svh
// Assertion macros for the scan minimum range steering block.
// ----------------------------------------------------------------------------
`ifndef SCAN_MIN_RANGE_STEERING_DEFINES_SVH
`define SCAN_MIN_RANGE_STEERING_DEFINES_SVH

// same-cycle implication, clocked on clk_i, disabled in reset
`define SMRS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("smrs assertion failed");

// next-cycle implication, clocked on clk_i, disabled in reset
`define SMRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("smrs assertion failed");

`endif

[rtl/core/smrs_pkg.sv]
// ----------------------------------------------------------------------------
// smrs_pkg
// Shared widths, register map and turn-rate table for the steering block.
// ----------------------------------------------------------------------------
`default_nettype none

package smrs_pkg;

  localparam int unsigned LenW            = 13;
  localparam int unsigned RangeW          = 16;
  localparam int unsigned SpeedW          = 19;
  localparam int unsigned TurnW           = 21;
  localparam int unsigned TurnMagW        = 20;
  localparam int unsigned DistW           = 10;
  localparam int unsigned DiffW           = 11;
  localparam int unsigned TurnLutDepth    = 201;
  localparam int unsigned DefMaxReadings  = 4096;
  localparam int unsigned ApbAddrW        = 3;
  localparam int unsigned ApbDataW        = 32;

  localparam logic [LenW-1:0]   ScanLengthReset = LenW'(360);
  localparam logic [RangeW-1:0] RangeMax        = '1;

  // register index decoded from paddr[2]
  localparam logic RegScanLength = 1'b0;

  // pi*1e6/900 scaled by 1e12
  localparam logic [63:0] TurnGain  = 64'd3490658503988659;
  localparam logic [63:0] TurnScale = 64'd1000000000000;
  localparam logic [63:0] TurnHalf  = 64'd500000000000;

  typedef logic [TurnMagW-1:0] turn_lut_t [0:TurnLutDepth-1];

  // rounded |d| * 3490.6585 for d in 0..200, built at elaboration
  function automatic turn_lut_t build_turn_lut();
    turn_lut_t   lut;
    logic [63:0] prod;
    for (int d = 0; d < TurnLutDepth; d++) begin
      prod   = 64'(d) * TurnGain + TurnHalf;
      lut[d] = TurnMagW'(prod / TurnScale);
    end
    return lut;
  endfunction

  localparam turn_lut_t TurnLut = build_turn_lut();

endpackage

`default_nettype wire

[rtl/core/scan_min_range_steering.sv]
// ----------------------------------------------------------------------------
// scan_min_range_steering
// Running right/left minimum over a laser scan, speed and turn command out.
// ----------------------------------------------------------------------------
// One range reading is taken per beat, one beat per cycle while s_axis_tready
// is high. Readings 0..N/2 feed the right minimum, N/2..N-1 the left one; the
// minimum update is combinational and keeps pace with that rate. The beat
// with tlast ends the scan: its speed/turn command passes a distance stage,
// then the output stage with a constant multiply and a 201-entry turn table.
// Two result stages buffer commands: input keeps flowing while one command
// waits for m_axis_tready, and stalls once a second one is pending.
// ----------------------------------------------------------------------------
`default_nettype none

`include "scan_min_range_steering_defines.svh"

module scan_min_range_steering #(
  parameter int unsigned MaxReadings = smrs_pkg::DefMaxReadings
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // config
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [smrs_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [smrs_pkg::ApbDataW-1:0] pwdata,
  output logic      [smrs_pkg::ApbDataW-1:0] prdata,
  output logic                               pready,
  // readings
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [15:0]                   s_axis_tdata,  // [15:0] range_mm
  input  wire logic                          s_axis_tlast,  // last_reading
  // commands
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic      [39:0]                   m_axis_tdata   // [18:0] speed_um_per_s,
                                                            // [39:19] turn_urad_per_s
);

  import smrs_pkg::*;

  localparam int unsigned CntW = (MaxReadings > 2) ? $clog2(MaxReadings) : 1;
  localparam int unsigned CmpW = ((LenW > CntW) ? LenW : CntW) + 2;
  localparam logic [CntW-1:0] IdxLast = CntW'(MaxReadings - 1);
  localparam logic [CmpW-1:0] LenMax  = CmpW'(MaxReadings);
  localparam logic [CmpW-1:0] LenMin  = CmpW'(2);
  localparam logic signed [SpeedW-1:0] SpeedGain = SpeedW'(200);
  localparam logic signed [DiffW-1:0]  DiffLim   = DiffW'(200);
  localparam logic [RangeW-1:0] DistOffset = RangeW'(500);
  localparam logic [RangeW-1:0] DistSat    = RangeW'(1000);

  // config register
  logic [LenW-1:0] scan_len_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegScanLength);
  assign prdata = (paddr[2] == RegScanLength) ? ApbDataW'(scan_len_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_len_q <= ScanLengthReset;
    end else if (cfg_wr) begin
      scan_len_q <= pwdata[LenW-1:0];
    end
  end

  // handshakes
  logic a_vld_q, out_vld_q;
  logic adv_out, in_acc;

  assign adv_out       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !a_vld_q || adv_out;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_vld_q;

  // scan state
  logic [CntW-1:0]   idx_q, idx_d;
  logic [RangeW-1:0] right_q, right_d, left_q, left_d;
  logic [RangeW-1:0] right_new, left_new;
  logic [CmpW-1:0]   len_raw, len_eff, mid, idx_ext;
  logic [RangeW-1:0] range_mm;
  logic              in_scan;

  assign range_mm = s_axis_tdata;
  assign len_raw  = CmpW'(scan_len_q);
  assign idx_ext  = CmpW'(idx_q);

  always_comb begin
    if (len_raw < LenMin) begin
      len_eff = LenMin;
    end else if (len_raw > LenMax) begin
      len_eff = LenMax;
    end else begin
      len_eff = len_raw;
    end
    mid     = len_eff >> 1;
    in_scan = idx_ext < len_eff;

    right_new = right_q;
    left_new  = left_q;
    if (in_scan && (idx_ext <= mid) && (range_mm < right_q)) begin
      right_new = range_mm;
    end
    if (in_scan && (idx_ext >= mid) && (range_mm < left_q)) begin
      left_new = range_mm;
    end

    idx_d   = idx_q;
    right_d = right_q;
    left_d  = left_q;
    if (in_acc) begin
      if (s_axis_tlast) begin
        idx_d   = '0;
        right_d = RangeMax;
        left_d  = RangeMax;
      end else begin
        idx_d   = (idx_q == IdxLast) ? idx_q : idx_q + CntW'(1);
        right_d = right_new;
        left_d  = left_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      right_q <= RangeMax;
      left_q  <= RangeMax;
    end else begin
      idx_q   <= idx_d;
      right_q <= right_d;
      left_q  <= left_d;
    end
  end

  // distance stage: min - 500, capped at 500
  logic signed [DistW-1:0] a_q, b_q, a_d, b_d;

  assign a_d = (right_new >= DistSat) ? DistW'(500) : DistW'(right_new - DistOffset);
  assign b_d = (left_new >= DistSat)  ? DistW'(500) : DistW'(left_new - DistOffset);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      a_vld_q <= in_acc && s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tlast) begin
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  // command stage
  logic signed [DiffW-1:0]  sum, diff, diff_clip;
  logic signed [SpeedW-1:0] sum_ext, speed_d, speed_q;
  logic        [7:0]        mag;
  logic        [TurnW-1:0]  turn_mag, turn_d, turn_q;

  always_comb begin
    sum     = DiffW'(a_q) + DiffW'(b_q);
    sum_ext = SpeedW'(sum);
    speed_d = sum_ext * SpeedGain;

    diff = DiffW'(b_q) - DiffW'(a_q);
    if (diff > DiffLim) begin
      diff_clip = DiffLim;
    end else if (diff < -DiffLim) begin
      diff_clip = -DiffLim;
    end else begin
      diff_clip = diff;
    end
    mag      = diff_clip[DiffW-1] ? 8'(-diff_clip) : 8'(diff_clip);
    turn_mag = TurnW'(TurnLut[mag]);
    turn_d   = diff_clip[DiffW-1] ? -turn_mag : turn_mag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv_out) begin
      out_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out && a_vld_q) begin
      speed_q <= speed_d;
      turn_q  <= turn_d;
    end
  end

  assign m_axis_tdata = {turn_q, speed_q};

  // checks
  `SMRS_ASSERT_NEXT(a_scan_restart, in_acc && s_axis_tlast,
                    idx_q == '0 && right_q == RangeMax && left_q == RangeMax)
  `SMRS_ASSERT_NEXT(a_idx_step, in_acc && !s_axis_tlast && idx_q != IdxLast,
                    idx_q == $past(idx_q) + CntW'(1))
  `SMRS_ASSERT_NOW(a_stall_full, !s_axis_tready, a_vld_q && out_vld_q)

endmodule

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the scan minimum range steering block.
// ----------------------------------------------------------------------------
// Laser readings are streamed in from a queue with random source gaps and
// sink stalls. Every accepted beat runs through a local copy of the scan
// minimum tracking, and each flagged last beat queues the expected speed and
// turn command. Commands out of the block are compared field by field in
// order. The scan length is rewritten between phases over its full range,
// including values outside the legal span and a write to an unused address.
// ----------------------------------------------------------------------------
module testbench;
  import smrs_pkg::*;

  localparam int Limit       = 1_000_000;
  localparam int MaxIdx      = 4095;
  localparam int MaxLen      = 4096;
  localparam int DrainCycles = 8;
  localparam int HoldCycles  = 300;

  localparam logic [ApbAddrW-1:0] ScanLenAddr = 3'd0;
  localparam logic [ApbAddrW-1:0] SpareAddr   = 3'd4;

  typedef struct packed {
    logic [RangeW-1:0] range_mm;
    logic              last_reading;
  } reading_t;

  typedef struct packed {
    logic signed [TurnW-1:0]  turn;
    logic signed [SpeedW-1:0] speed;
  } steer_cmd_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [ApbAddrW-1:0] paddr         = '0;
  logic [ApbDataW-1:0] pwdata        = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata  = '0;  // [15:0] range_mm
  logic                s_axis_tlast  = 1'b0; // last_reading
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [39:0]         m_axis_tdata;        // [18:0] speed, [39:19] turn

  reading_t   reading_q[$];
  steer_cmd_t cmd_q[$];

  int errors          = 0;
  int cmds_seen       = 0;
  int readings_taken  = 0;
  int readings_queued = 0;
  int writes_done     = 0;
  int send_gap        = 0;
  int recv_gap        = 0;
  int hold_left       = 0;
  int hold_asked      = 0;
  int hold_done       = 0;
  int cycles          = 0;
  bit quiet           = 1'b0;

  // local copy of the block state
  logic [LenW-1:0]   len_reg   = 13'd360;
  int                scan_idx  = 0;
  logic [RangeW-1:0] right_min = '1;
  logic [RangeW-1:0] left_min  = '1;

  scan_min_range_steering uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic int eff_len(logic [LenW-1:0] v);
    int n;
    n = int'(v);
    if (n < 2) n = 2;
    if (n > MaxLen) n = MaxLen;
    return n;
  endfunction

  function automatic int clamp_dist(logic [RangeW-1:0] m);
    int v;
    v = int'(m) - 500;
    return (v > 500) ? 500 : v;
  endfunction

  function automatic steer_cmd_t steer_cmd(logic [RangeW-1:0] rmin, logic [RangeW-1:0] lmin);
    int                a;
    int                b;
    int                d;
    longint unsigned   mag;
    steer_cmd_t        c;
    a = clamp_dist(rmin);
    b = clamp_dist(lmin);
    d = b - a;
    if (d > 200) d = 200;
    if (d < -200) d = -200;
    mag = (d < 0) ? -d : d;
    // pi*1e6/900 in fixed point, rounded half away from zero
    mag = (mag * 64'd3490658503988659 + 64'd500000000000) / 64'd1000000000000;
    c.speed = SpeedW'(200 * (a + b));
    c.turn  = (d < 0) ? -TurnW'(mag) : TurnW'(mag);
    return c;
  endfunction

  task automatic track_reading(logic [RangeW-1:0] r, logic last);
    int n;
    int mid;
    n   = eff_len(len_reg);
    mid = n / 2;
    if (scan_idx < n) begin
      if (scan_idx <= mid && r < right_min) right_min = r;
      if (scan_idx >= mid && r < left_min) left_min = r;
    end
    if (scan_idx < MaxIdx) scan_idx++;
    readings_taken++;
    if (last) begin
      cmd_q.insert(cmd_q.size(), steer_cmd(right_min, left_min));
      scan_idx  = 0;
      right_min = '1;
      left_min  = '1;
    end
  endtask

  task automatic note_mismatch(string what, int got, int want);
    $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  // source side
  always @(posedge clk_i) begin
    reading_t nxt;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) track_reading(s_axis_tdata, s_axis_tlast);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (reading_q.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 17);
          s_axis_tvalid <= 1'b0;
        end else begin
          nxt = reading_q.pop_front();
          s_axis_tdata  <= nxt.range_mm;
          s_axis_tlast  <= nxt.last_reading;
          s_axis_tvalid <= 1'b1;
        end
      end
    end
  end

  // sink side
  always @(posedge clk_i) begin
    steer_cmd_t got;
    steer_cmd_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        cmds_seen++;
        if (cmd_q.size() == 0) begin
          note_mismatch("unexpected command, speed", int'(got.speed), 0);
        end else begin
          want = cmd_q.pop_front();
          if (got.speed !== want.speed) note_mismatch("speed", int'(got.speed), int'(want.speed));
          if (got.turn !== want.turn) note_mismatch("turn", int'(got.turn), int'(want.turn));
        end
      end
      if (hold_asked != hold_done) begin
        hold_done++;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        recv_gap = $urandom_range(0, 17);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= Limit) begin
      $display("%0t timeout", $time);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [RangeW-1:0] pick_range();
    case ($urandom_range(0, 7))
      0, 1:    return RangeW'($urandom);
      2:       return '1;
      3:       return RangeW'($urandom_range(0, 20));
      default: return RangeW'($urandom_range(0, 1100));
    endcase
  endfunction

  task automatic push_reading(int r, bit last);
    reading_t it;
    it.range_mm     = RangeW'(r);
    it.last_reading = last;
    reading_q.insert(reading_q.size(), it);
    readings_queued++;
  endtask

  task automatic write_reg(logic [ApbAddrW-1:0] addr, logic [ApbDataW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr[2] == RegScanLength) len_reg = data[LenW-1:0];
    writes_done++;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (readings_taken != readings_queued || cmd_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic run_scans(int len_val, int budget, bit hold);
    int n;
    int cnt;
    int sl;
    write_reg(ScanLenAddr, ApbDataW'(len_val));
    n   = eff_len(LenW'(len_val));
    cnt = 0;
    while (cnt < budget) begin
      // mostly full scans, the rest end early or run past the length
      sl = ($urandom_range(0, 9) < 7) ? n : $urandom_range(1, n + 4);
      for (int k = 0; k < sl; k++) push_reading(pick_range(), k == sl - 1);
      cnt += sl;
    end
    if (hold) hold_asked++;
    wait_drained();
  endtask

  initial begin
    int sl;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset length: one-beat scans leave the left half empty
    push_reading(0, 1);
    push_reading(65535, 1);
    push_reading(1000, 0);
    push_reading(300, 1);
    wait_drained();

    // length below the minimum, readings past the end of the scan
    write_reg(ScanLenAddr, '0);
    push_reading(65535, 0);
    push_reading(0, 1);
    push_reading(0, 0);
    push_reading(1000, 0);
    push_reading(1000, 0);
    push_reading(5, 1);
    wait_drained();

    // upper data bits dropped, unused address ignored
    write_reg(ScanLenAddr, 32'hFFFF_E003);
    write_reg(SpareAddr, 32'h2);
    push_reading(1000, 0);
    push_reading(1000, 0);
    push_reading(0, 1);
    push_reading(750, 0);
    push_reading(600, 0);
    push_reading(800, 1);
    push_reading(499, 0);
    push_reading(501, 0);
    push_reading(1001, 1);
    wait_drained();

    run_scans(2, 150, 1'b0);
    run_scans(1, 120, 1'b1);
    run_scans(3, 150, 1'b0);
    run_scans(5, 150, 1'b0);
    run_scans(17, 150, 1'b0);
    run_scans(64, 200, 1'b0);
    run_scans(360, 1, 1'b0);

    // oversized length clamps to the longest scan, all readings land right
    write_reg(ScanLenAddr, 32'd8191);
    for (int k = 0; k < 40; k++) push_reading(pick_range(), k == 39);
    wait_drained();

    write_reg(ScanLenAddr, 32'd4096);
    repeat (4) begin
      sl = $urandom_range(1, 40);
      for (int k = 0; k < sl; k++) push_reading(pick_range(), k == sl - 1);
    end
    wait_drained();

    quiet = 1'b1;
    run_scans(7, 60, 1'b0);

    $display("Checked %0d commands from %0d readings across %0d register writes.",
             cmds_seen, readings_taken, writes_done);
    $display("Lengths below 2 to past 4096, early and overrun scans, long backpressure.");
    if (errors == 0 && cmd_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
